@@ sv/hmd_pkg.sv @@
// Shared word types and command/status codes for the HTTP message deframer.
`timescale 1ns / 1ps

package hmd_pkg;

  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int PAY_LEN_W  = 32;

  localparam logic [CMD_W-1:0] CMD_BYTE         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN_HEADER  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN_LINE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OPEN_PAYLOAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OPEN_CHUNKED = 3'd4;
  localparam logic [CMD_W-1:0] CMD_END_INPUT    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLOSE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HOLD     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [7:0]           data_byte;
    logic [PAY_LEN_W-1:0] payload_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                out_valid;
    logic                unit_end;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

@@ sv/hmd_in_reg.sv @@
// Input register: holds one accepted word until the step logic takes it.
`timescale 1ns / 1ps

module hmd_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  hmd_pkg::in_item_t item,
  output logic              held_valid,
  output hmd_pkg::in_item_t held_item,
  input  logic              take
);

  logic full;
  hmd_pkg::in_item_t data;

  assign item_ready = !full || take;
  assign held_valid = full;
  assign held_item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_valid && item_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      data <= item;
    end
  end

endmodule

@@ sv/hmd_core.sv @@
// Unit state and the combinational step that turns one word into one result.
`timescale 1ns / 1ps

module hmd_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               held_valid,
  input  hmd_pkg::in_item_t  held_item,
  input  logic               space,
  output logic               take,
  output logic               push,
  output hmd_pkg::out_item_t res
);

  typedef enum logic [2:0] {
    M_IDLE, M_HEADER, M_LINE, M_PAYLOAD, M_SIZE, M_DATA, M_AFTER_DATA, M_TRAILER
  } mode_t;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  mode_t                  unit_mode, unit_mode_next;
  logic [1:0]             newline_count, newline_count_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic                   size_digit_seen, size_digit_seen_next;
  logic                   size_trailing_space, size_trailing_space_next;
  logic                   input_ended, input_ended_next;

  logic [LENGTH_BITS-1:0] len_sat;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [1:0]             nl_inc;
  logic [7:0]             c;
  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic                   blank;
  logic                   bad_mark;

  generate
    if (LENGTH_BITS >= hmd_pkg::PAY_LEN_W) begin : g_len_wide
      assign len_sat = LENGTH_BITS'(held_item.payload_length);
    end else begin : g_len_narrow
      assign len_sat = (|held_item.payload_length[hmd_pkg::PAY_LEN_W-1:LENGTH_BITS])
                     ? '1 : held_item.payload_length[LENGTH_BITS-1:0];
    end
  endgenerate

  assign c        = held_item.data_byte;
  assign left_dec = bytes_left - LENGTH_BITS'(1);
  assign bad_mark = !size_digit_seen && size_trailing_space;
  assign blank    = (c == 8'h20) || (c == 8'h09) || (c == CH_CR) ||
                    (c == 8'h0B) || (c == 8'h0C);

  // LF raises the count, CR leaves it, anything else clears it.
  always_comb begin
    if (c == CH_LF) begin
      nl_inc = newline_count + 2'd1;
    end else if (c == CH_CR) begin
      nl_inc = newline_count;
    end else begin
      nl_inc = 2'd0;
    end
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign take = held_valid && space;
  assign push = take;

  always_comb begin
    unit_mode_next           = unit_mode;
    newline_count_next       = newline_count;
    bytes_left_next          = bytes_left;
    size_digit_seen_next     = size_digit_seen;
    size_trailing_space_next = size_trailing_space;
    input_ended_next         = input_ended;
    res                      = '0;

    unique case (held_item.command)
      hmd_pkg::CMD_BYTE: begin
        if (input_ended || unit_mode == M_IDLE) begin
          res.status = hmd_pkg::ST_HOLD;
        end else begin
          unique case (unit_mode)
            M_HEADER, M_LINE: begin
              res.out_byte  = c;
              res.out_valid = 1'b1;
              newline_count_next = nl_inc;
              if (nl_inc >= ((unit_mode == M_HEADER) ? 2'd2 : 2'd1)) begin
                unit_mode_next     = M_IDLE;
                newline_count_next = 2'd0;
                res.unit_end       = 1'b1;
              end
            end
            M_PAYLOAD: begin
              res.out_byte    = c;
              res.out_valid   = 1'b1;
              bytes_left_next = left_dec;
              if (left_dec == '0) begin
                unit_mode_next = M_IDLE;
                res.unit_end   = 1'b1;
              end
            end
            M_DATA: begin
              res.out_byte    = c;
              res.out_valid   = 1'b1;
              bytes_left_next = left_dec;
              if (left_dec == '0) begin
                unit_mode_next     = M_AFTER_DATA;
                newline_count_next = 2'd0;
              end
            end
            M_SIZE: begin
              if (c == CH_LF) begin
                if (bad_mark || !size_digit_seen) begin
                  unit_mode_next           = M_IDLE;
                  bytes_left_next          = '0;
                  size_digit_seen_next     = 1'b0;
                  size_trailing_space_next = 1'b0;
                  res.status               = hmd_pkg::ST_BAD_SIZE;
                end else begin
                  if (bytes_left == '0) begin
                    unit_mode_next     = M_TRAILER;
                    newline_count_next = 2'd1;
                  end else begin
                    unit_mode_next = M_DATA;
                  end
                  size_digit_seen_next     = 1'b0;
                  size_trailing_space_next = 1'b0;
                end
              end else if (!bad_mark) begin
                if (blank) begin
                  if (size_digit_seen) begin
                    size_trailing_space_next = 1'b1;
                  end
                end else if (hex_ok && !size_trailing_space &&
                             bytes_left[LENGTH_BITS-1 -: 4] == 4'd0) begin
                  bytes_left_next      = {bytes_left[LENGTH_BITS-5:0], hex_val};
                  size_digit_seen_next = 1'b1;
                end else begin
                  size_digit_seen_next     = 1'b0;
                  size_trailing_space_next = 1'b1;
                end
              end
            end
            M_AFTER_DATA: begin
              newline_count_next = nl_inc;
              if (nl_inc >= 2'd1) begin
                unit_mode_next           = M_SIZE;
                newline_count_next       = 2'd0;
                bytes_left_next          = '0;
                size_digit_seen_next     = 1'b0;
                size_trailing_space_next = 1'b0;
              end
            end
            M_TRAILER: begin
              newline_count_next = nl_inc;
              if (nl_inc >= 2'd2) begin
                unit_mode_next     = M_IDLE;
                newline_count_next = 2'd0;
                res.unit_end       = 1'b1;
              end
            end
            default: begin
              res.status = hmd_pkg::ST_HOLD;
            end
          endcase
        end
      end
      hmd_pkg::CMD_OPEN_HEADER: begin
        if (input_ended) begin
          res = '0;
        end else if ((unit_mode == M_PAYLOAD || unit_mode == M_DATA) &&
                     bytes_left != '0) begin
          res.status = hmd_pkg::ST_CLOSE;
        end else begin
          unit_mode_next     = M_HEADER;
          newline_count_next = 2'd0;
        end
      end
      hmd_pkg::CMD_OPEN_LINE, hmd_pkg::CMD_OPEN_PAYLOAD, hmd_pkg::CMD_OPEN_CHUNKED: begin
        if (input_ended) begin
          res.status = hmd_pkg::ST_CLOSE;
        end else begin
          newline_count_next       = 2'd0;
          bytes_left_next          = '0;
          size_digit_seen_next     = 1'b0;
          size_trailing_space_next = 1'b0;
          if (held_item.command == hmd_pkg::CMD_OPEN_LINE) begin
            unit_mode_next = M_LINE;
          end else if (held_item.command == hmd_pkg::CMD_OPEN_CHUNKED) begin
            unit_mode_next = M_SIZE;
          end else if (held_item.payload_length == '0) begin
            unit_mode_next = M_IDLE;
            res.unit_end   = 1'b1;
          end else begin
            bytes_left_next = len_sat;
            unit_mode_next  = M_PAYLOAD;
          end
        end
      end
      hmd_pkg::CMD_END_INPUT: begin
        res.unit_end             = (unit_mode != M_IDLE);
        input_ended_next         = 1'b1;
        unit_mode_next           = M_IDLE;
        newline_count_next       = 2'd0;
        bytes_left_next          = '0;
        size_digit_seen_next     = 1'b0;
        size_trailing_space_next = 1'b0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode           <= M_IDLE;
      newline_count       <= 2'd0;
      bytes_left          <= '0;
      size_digit_seen     <= 1'b0;
      size_trailing_space <= 1'b0;
      input_ended         <= 1'b0;
    end else if (take) begin
      unit_mode           <= unit_mode_next;
      newline_count       <= newline_count_next;
      bytes_left          <= bytes_left_next;
      size_digit_seen     <= size_digit_seen_next;
      size_trailing_space <= size_trailing_space_next;
      input_ended         <= input_ended_next;
    end
  end

  a_ended_sticks: assert property (@(posedge clk) disable iff (rst)
    input_ended |=> input_ended)
    else $error("end of input flag cleared without reset");

  a_quiet_byte_zero: assert property (@(posedge clk) disable iff (rst)
    push && !res.out_valid |-> res.out_byte == 8'd0)
    else $error("byte not passed on but result byte is nonzero");

  a_bad_size_drops: assert property (@(posedge clk) disable iff (rst)
    push && res.status == hmd_pkg::ST_BAD_SIZE |=> unit_mode == M_IDLE)
    else $error("bad chunk size did not drop the unit");

endmodule

@@ sv/hmd_out_fifo.sv @@
// Two-entry result buffer that parts the step logic from the output handshake.
`timescale 1ns / 1ps

module hmd_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hmd_pkg::out_item_t res,
  output logic               space,
  output logic               result_valid,
  input  logic               result_ready,
  output hmd_pkg::out_item_t result
);

  hmd_pkg::out_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = (count != 2'd0);
  assign result       = mem[rd_ptr];
  assign space        = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push)
    else $error("result written into a full buffer");

endmodule

@@ sv/http_message_deframer.sv @@
// Top level of the HTTP message deframer: input register, step logic, result buffer.
`timescale 1ns / 1ps

// HTTP message deframer. Each input word is either a stream byte or a command
// that opens a unit (header, line, fixed-length payload, chunked body) or marks
// the end of input; every word produces exactly one result word. Header and
// line units pass bytes through until a blank line or a single newline; a
// payload passes its byte count; a chunked body parses the hex size line,
// passes the data, swallows the CRLF after it and, after the zero chunk, the
// trailer up to a blank line. unit_end marks the word that finishes a unit.
// Status 3 means the byte found no open unit: hold it upstream and resend it
// after opening one. Throughput is one word per clock while the result buffer
// has room; an accepted word is loaded into the input register, then the state
// update runs on it and writes its result into the buffer once there is room.
// The result buffer holds two words, so a stalled consumer backs up into the
// input register and then deasserts item_ready. LENGTH_BITS sets the width of
// the byte counter; payload lengths above it saturate and chunk sizes above it
// are reported as bad.

module http_message_deframer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  hmd_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output hmd_pkg::out_item_t result
);

  // Word waiting in the input register.
  logic              held_valid;
  hmd_pkg::in_item_t held_item;

  // Step handshake: take the held word when the result buffer has room.
  logic               take;
  logic               push;
  logic               space;
  hmd_pkg::out_item_t res;

  // Hold each accepted word until the step logic consumes it.
  hmd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  // Advance the unit state by one word and form its result.
  hmd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .space      (space),
    .take       (take),
    .push       (push),
    .res        (res)
  );

  // Buffer results so a stalled consumer blocks the step logic only once the buffer is full.
  hmd_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res          (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ sim/tb_http_message_deframer.sv @@
// Self-checking testbench for the HTTP message deframer: directed units, then random traffic.
`timescale 1ns / 1ps

module tb_http_message_deframer;

  localparam int          LEN_BITS     = 32;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_WORDS = 1400;
  localparam int          CALM_WORDS   = 150;

  // Spare command codes: the block must answer them with an all-zero word.
  localparam logic [hmd_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [hmd_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [2:0] {
    U_IDLE, U_HEADER, U_LINE, U_PAYLOAD, U_SIZE, U_DATA, U_AFTER_DATA, U_TRAILER
  } unit_mode_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  hmd_pkg::in_item_t  item         = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  hmd_pkg::out_item_t result;

  http_message_deframer #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Predicted deframer state, starting from its reset values.
  unit_mode_t          cur_mode      = U_IDLE;
  logic [1:0]          lf_run        = '0;
  logic [LEN_BITS-1:0] remaining     = '0;
  logic                hex_seen      = 1'b0;
  logic                hex_closed    = 1'b0;
  logic                stream_closed = 1'b0;

  hmd_pkg::out_item_t pending_results[$];
  int          words_sent   = 0;
  int          noise_words  = 0;
  int          mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  logic        gaps_on      = 1'b1;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_size_state();
    remaining  = '0;
    hex_seen   = 1'b0;
    hex_closed = 1'b0;
  endfunction

  // Track runs of LF; CR leaves the run alone, any other byte breaks it.
  function automatic bit bump_newline(input logic [7:0] c, input int limit);
    if (c == CH_LF) begin
      lf_run = lf_run + 2'd1;
    end else if (c != CH_CR) begin
      lf_run = '0;
    end
    return lf_run >= limit;
  endfunction

  function automatic hmd_pkg::out_item_t deframe_word(input hmd_pkg::in_item_t w);
    hmd_pkg::out_item_t r;
    logic [7:0]         c;
    int                 hv;
    bit                 bad;
    r = '0;
    c = w.data_byte;
    case (w.command)
      hmd_pkg::CMD_BYTE: begin
        if (stream_closed || cur_mode == U_IDLE) begin
          r.status = hmd_pkg::ST_HOLD;
        end else begin
          case (cur_mode)
            U_HEADER, U_LINE: begin
              r.out_byte  = c;
              r.out_valid = 1'b1;
              if (bump_newline(c, cur_mode == U_HEADER ? 2 : 1)) begin
                cur_mode   = U_IDLE;
                lf_run     = '0;
                r.unit_end = 1'b1;
              end
            end
            U_PAYLOAD: begin
              r.out_byte  = c;
              r.out_valid = 1'b1;
              remaining   = remaining - 1'b1;
              if (remaining == '0) begin
                cur_mode   = U_IDLE;
                r.unit_end = 1'b1;
              end
            end
            U_SIZE: begin
              // Closed with no digit pending: the size is already bad.
              bad = !hex_seen && hex_closed;
              if (c == CH_LF) begin
                if (bad || !hex_seen) begin
                  cur_mode = U_IDLE;
                  clear_size_state();
                  r.status = hmd_pkg::ST_BAD_SIZE;
                end else begin
                  if (remaining == '0) begin
                    cur_mode = U_TRAILER;
                    lf_run   = 2'd1;
                  end else begin
                    cur_mode = U_DATA;
                  end
                  hex_seen   = 1'b0;
                  hex_closed = 1'b0;
                end
              end else if (!bad) begin
                hv = -1;
                if (c >= "0" && c <= "9") hv = c - "0";
                else if (c >= "a" && c <= "f") hv = c - "a" + 10;
                else if (c >= "A" && c <= "F") hv = c - "A" + 10;
                if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF) begin
                  if (hex_seen) hex_closed = 1'b1;
                end else if (hv >= 0 && !hex_closed &&
                             remaining[LEN_BITS-1 -: 4] == 4'd0) begin
                  remaining = {remaining[LEN_BITS-5:0], 4'(hv)};
                  hex_seen  = 1'b1;
                end else begin
                  hex_seen   = 1'b0;
                  hex_closed = 1'b1;
                end
              end
            end
            U_DATA: begin
              r.out_byte  = c;
              r.out_valid = 1'b1;
              remaining   = remaining - 1'b1;
              if (remaining == '0) begin
                cur_mode = U_AFTER_DATA;
                lf_run   = '0;
              end
            end
            U_AFTER_DATA: begin
              if (bump_newline(c, 1)) begin
                cur_mode = U_SIZE;
                lf_run   = '0;
                clear_size_state();
              end
            end
            default: begin
              if (bump_newline(c, 2)) begin
                cur_mode   = U_IDLE;
                lf_run     = '0;
                r.unit_end = 1'b1;
              end
            end
          endcase
        end
      end
      hmd_pkg::CMD_OPEN_HEADER: begin
        if (stream_closed) begin
          r = '0;
        end else if ((cur_mode == U_PAYLOAD || cur_mode == U_DATA) && remaining != '0) begin
          r.status = hmd_pkg::ST_CLOSE;
        end else begin
          cur_mode = U_HEADER;
          lf_run   = '0;
        end
      end
      hmd_pkg::CMD_OPEN_LINE, hmd_pkg::CMD_OPEN_PAYLOAD, hmd_pkg::CMD_OPEN_CHUNKED: begin
        if (stream_closed) begin
          r.status = hmd_pkg::ST_CLOSE;
        end else begin
          lf_run = '0;
          clear_size_state();
          if (w.command == hmd_pkg::CMD_OPEN_LINE) begin
            cur_mode = U_LINE;
          end else if (w.command == hmd_pkg::CMD_OPEN_CHUNKED) begin
            cur_mode = U_SIZE;
          end else if (w.payload_length == '0) begin
            cur_mode   = U_IDLE;
            r.unit_end = 1'b1;
          end else begin
            remaining = w.payload_length;
            cur_mode  = U_PAYLOAD;
          end
        end
      end
      hmd_pkg::CMD_END_INPUT: begin
        r.unit_end    = (cur_mode != U_IDLE);
        stream_closed = 1'b1;
        cur_mode      = U_IDLE;
        lf_run        = '0;
        clear_size_state();
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word driver: call at a rising edge, returns at the edge that accepts the word
  // ---------------------------------------------------------------------------

  task automatic send_word(input logic [hmd_pkg::CMD_W-1:0] cmd, input logic [7:0] b,
                           input logic [hmd_pkg::PAY_LEN_W-1:0] len);
    hmd_pkg::in_item_t w;
    w.command        = cmd;
    w.data_byte      = b;
    w.payload_length = len;
    // Drop valid for a random burst now and then; otherwise keep it high.
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    pending_results.push_back(deframe_word(w));
    words_sent++;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_word(hmd_pkg::CMD_BYTE, b, $urandom());
  endtask

  // Open a unit with random filler in the fields the command ignores.
  task automatic open_unit(input logic [hmd_pkg::CMD_W-1:0] cmd);
    send_word(cmd, 8'($urandom_range(0, 255)), $urandom());
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Any byte but LF, so a text line cannot end early.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LF) ? 8'h78 : b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  task automatic line_end();
    if ($urandom_range(0, 3) != 0) put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  // Send a chunk size line: optional blanks around mixed-case hex, leading zeros.
  task automatic size_line(input int unsigned v);
    string      hex;
    logic [7:0] ch;
    hex = $sformatf("%0h", v);
    repeat ($urandom_range(0, 2)) hex = {"0", hex};
    repeat ($urandom_range(0, 2)) put_byte(blank_byte());
    for (int i = 0; i < hex.len(); i++) begin
      ch = hex[i];
      if (ch >= "a" && $urandom_range(0, 1) == 1) ch = ch - 8'h20;
      put_byte(ch);
    end
    repeat ($urandom_range(0, 2)) put_byte(blank_byte());
    line_end();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and result-side stalls
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input hmd_pkg::out_item_t want,
                               input hmd_pkg::out_item_t got);
    if (mismatches < 10) begin
      $display("%0t %s: expected byte %02h valid %0b end %0b status %0d", $time, what,
               want.out_byte, want.out_valid, want.unit_end, want.status);
      $display("%0t %s:      got byte %02h valid %0b end %0b status %0d", $time, what,
               got.out_byte, got.out_valid, got.unit_end, got.status);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    hmd_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, result);
      end else begin
        want = pending_results.pop_front();
        if (result.out_byte !== want.out_byte || result.out_valid !== want.out_valid ||
            result.unit_end !== want.unit_end || result.status !== want.status)
          note_mismatch("result mismatch", want, result);
      end
    end
  end

  // Hold ready low for random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 8);
    if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_http_message_deframer failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_header_and_line();
    // Header ends on the second LF; the CR between them must not break the run.
    open_unit(hmd_pkg::CMD_OPEN_HEADER);
    put_text("A\r\n\r\n");
    // Nothing open: the byte must be held upstream.
    put_byte(8'h00);
    open_unit(hmd_pkg::CMD_OPEN_LINE);
    put_byte(8'hFF);
    put_byte(CH_LF);
  endtask

  task automatic test_payload();
    send_word(hmd_pkg::CMD_OPEN_PAYLOAD, 8'h5A, 32'd2);
    put_byte(8'h00);
    put_byte(8'hFF);
    // Zero length finishes on the open itself.
    send_word(hmd_pkg::CMD_OPEN_PAYLOAD, 8'hA5, 32'd0);
    // Open a header mid payload: close request, payload stays open.
    send_word(hmd_pkg::CMD_OPEN_PAYLOAD, 8'h00, 32'hFFFF_FFFF);
    put_byte(8'h41);
    open_unit(hmd_pkg::CMD_OPEN_HEADER);
  endtask

  task automatic test_chunked();
    // One data byte, CRLF after it, zero chunk, empty trailer.
    open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
    put_text(" 1\r\nz\r\n0\n\n");
    // Empty size line is a bad size.
    open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
    put_byte(CH_LF);
  endtask

  task automatic test_unused_commands();
    open_unit(CMD_SPARE_6);
    open_unit(CMD_SPARE_7);
  endtask

  task automatic rand_header();
    open_unit(hmd_pkg::CMD_OPEN_HEADER);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 10)) put_byte(text_byte());
      line_end();
    end
    line_end();
  endtask

  task automatic rand_line();
    open_unit(hmd_pkg::CMD_OPEN_LINE);
    repeat ($urandom_range(0, 12)) put_byte(text_byte());
    line_end();
  endtask

  task automatic rand_payload();
    int unsigned n;
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
    send_word(hmd_pkg::CMD_OPEN_PAYLOAD, 8'($urandom_range(0, 255)), n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic rand_chunked();
    int unsigned n;
    open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
    repeat ($urandom_range(0, 3)) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      size_line(n);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      // Junk before the line break after data is swallowed too.
      if ($urandom_range(0, 7) == 0) put_byte(text_byte());
      line_end();
    end
    size_line(0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 8)) put_byte(text_byte());
      line_end();
    end
    line_end();
  endtask

  // Broken sequences: bad sizes, and units abandoned by a refused header open.
  task automatic rand_broken();
    string junk;
    junk = ";gx-=Z.";
    case ($urandom_range(0, 5))
      0: begin
        open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
        repeat ($urandom_range(0, 2)) put_byte(blank_byte());
        line_end();
      end
      1: begin
        open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
        repeat ($urandom_range(0, 3)) put_byte("7");
        put_byte(junk[$urandom_range(0, junk.len() - 1)]);
        if ($urandom_range(0, 1) == 1) put_byte("a");
        line_end();
      end
      2: begin
        // Blank between digits.
        open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
        put_byte("1");
        put_byte(blank_byte());
        put_byte("2");
        put_byte(CH_LF);
      end
      3: begin
        // Nine significant digits overflow the counter.
        open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
        put_byte("1");
        repeat (8) put_byte("0");
        line_end();
      end
      4: begin
        open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
        size_line($urandom() | 32'h1000_0000);
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        open_unit(hmd_pkg::CMD_OPEN_HEADER);
        open_unit(hmd_pkg::CMD_OPEN_LINE);
        put_byte(CH_LF);
      end
      default: begin
        send_word(hmd_pkg::CMD_OPEN_PAYLOAD, 8'($urandom_range(0, 255)),
                  $urandom() | 32'h100);
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        open_unit(hmd_pkg::CMD_OPEN_HEADER);
        open_unit(hmd_pkg::CMD_OPEN_LINE);
        put_byte(CH_LF);
      end
    endcase
  endtask

  // Any word but end of input, with random fields.
  task automatic rand_noise();
    logic [hmd_pkg::CMD_W-1:0] cmd;
    do cmd = hmd_pkg::CMD_W'($urandom_range(0, 7)); while (cmd == hmd_pkg::CMD_END_INPUT);
    send_word(cmd, 8'($urandom_range(0, 255)), $urandom());
    noise_words++;
  endtask

  task automatic test_random_traffic();
    int pick;
    while (words_sent - noise_words < RANDOM_WORDS) begin
      // Switch idling on and off per unit; the final stretch runs at full rate.
      if (words_sent - noise_words >= RANDOM_WORDS - CALM_WORDS) gaps_on <= 1'b0;
      else if ($urandom_range(0, 3) == 0) gaps_on <= !gaps_on;
      pick = $urandom_range(0, 19);
      if (pick < 4) rand_header();
      else if (pick < 7) rand_line();
      else if (pick < 10) rand_payload();
      else if (pick < 16) rand_chunked();
      else if (pick < 18) rand_broken();
      else rand_noise();
    end
  endtask

  // End of input is final: run it last, then probe that everything is refused.
  task automatic test_end_of_input();
    gaps_on <= 1'b0;
    open_unit(hmd_pkg::CMD_OPEN_HEADER);
    open_unit(hmd_pkg::CMD_END_INPUT);
    put_byte(8'h41);
    send_word(hmd_pkg::CMD_OPEN_PAYLOAD, 8'h00, 32'd4);
    open_unit(hmd_pkg::CMD_OPEN_LINE);
    open_unit(hmd_pkg::CMD_OPEN_CHUNKED);
    open_unit(hmd_pkg::CMD_OPEN_HEADER);
    open_unit(hmd_pkg::CMD_END_INPUT);
    open_unit(CMD_SPARE_7);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_header_and_line();
    test_payload();
    test_chunked();
    test_unused_commands();
    test_random_traffic();
    test_end_of_input();
    item_valid <= 1'b0;
    // Drain the remaining results, then wait for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_http_message_deframer passed");
    end else begin
      $display("tb_http_message_deframer failed");
    end
    $finish;
  end

endmodule
